// ===== sv/lpbm_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lpbm_pkg
// Shared types, constants and helpers of the LED panel bitplane mapper.
// -----------------------------------------------------------------------------
package lpbm_pkg;

  // Store geometry: one RAM word holds the entry of every plane at one
  // (scan row, column) place, plane p in bits [6p+5:6p].
  localparam int NumPlanes = 3;
  localparam int NumRows   = 8;
  localparam int NumCols   = 256;
  localparam int EntryW    = 6;
  localparam int SlotW     = 3;
  localparam int RowW      = $clog2(NumRows);
  localparam int ColW      = $clog2(NumCols);
  localparam int RamDepth  = NumRows * NumCols;
  localparam int RamAddrW  = $clog2(RamDepth);
  localparam int RamWidth  = NumPlanes * EntryW;

  // Colour word fields
  localparam logic [15:0] RedMask   = 16'hC000;
  localparam logic [15:0] GreenMask = 16'h0600;
  localparam logic [15:0] BlueMask  = 16'h0018;
  localparam int          RedLsb    = 14;
  localparam int          GreenLsb  = 9;
  localparam int          BlueLsb   = 3;
  localparam logic [SlotW-1:0] SlotMask = 3'h7;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_READ  = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_EXEC  = 2'd2
  } state_e;

  // Mapped request: store address, slot and the per-plane RGB bits
  typedef struct packed {
    logic [RamAddrW-1:0]               addr;
    logic                              upper;
    logic [NumPlanes-1:0][SlotW-1:0]   bits;
  } lpbm_map_t;

  // RAM write port
  typedef struct packed {
    logic                 we;
    logic [RamAddrW-1:0]  addr;
    logic [RamWidth-1:0]  data;
  } lpbm_wr_t;

  // 2-bit level to 3-bit thermometer code
  function automatic logic [SlotW-1:0] thermo(input logic [1:0] level);
    logic [SlotW-1:0] code;
    unique case (level)
      2'd0:    code = 3'b000;
      2'd1:    code = 3'b001;
      2'd2:    code = 3'b011;
      default: code = 3'b111;
    endcase
    return code & SlotMask;
  endfunction

endpackage

// ===== sv/lpbm_ram.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lpbm_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// -----------------------------------------------------------------------------
module lpbm_ram #(
  parameter int Width = 8,
  parameter int Depth = 256,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/lpbm_map.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lpbm_map
// Maps a pixel to scan row, shifted column and slot, and splits its colour
// into per-plane RGB bits. Reads take their address from the request fields.
// -----------------------------------------------------------------------------
module lpbm_map import lpbm_pkg::*; (
  input  logic        req_type_i,
  input  logic [5:0]  x_pos_i,
  input  logic [5:0]  y_pos_i,
  input  logic [15:0] color_i,
  input  logic [2:0]  scan_row_i,
  input  logic [7:0]  column_sel_i,
  output lpbm_map_t   map_o
);

  logic [2:0]       pan;
  logic [1:0]       pan_sel;
  logic [5:0]       col_low;
  logic [ColW-1:0]  col;
  logic [RowW-1:0]  row;
  logic             upper;
  logic [SlotW-1:0] red;
  logic [SlotW-1:0] gre;
  logic [SlotW-1:0] blu;

  // Panel index and column within the scan row
  always_comb begin
    pan     = 3'({2'b00, x_pos_i[5]}) + 3'({1'b0, y_pos_i[5:4]});
    upper   = y_pos_i[4];
    row     = y_pos_i[2:0];
    // rows 8..15 of a panel half sit in the first 32 columns
    col_low = {~y_pos_i[3], x_pos_i[4:0]};
    pan_sel = upper ? 2'(pan + 3'd3) : pan[1:0];
    col     = {pan_sel, col_low};
  end

  // Thermometer codes of the colour levels
  always_comb begin
    red = thermo(2'((color_i & RedMask)   >> RedLsb));
    gre = thermo(2'((color_i & GreenMask) >> GreenLsb));
    blu = thermo(2'((color_i & BlueMask)  >> BlueLsb));
  end

  // Address select and plane bits
  always_comb begin
    map_o.upper = upper;
    for (int p = 0; p < NumPlanes; p++) begin
      map_o.bits[p] = {blu[p], gre[p], red[p]};
    end
    if (req_type_i == REQ_READ) begin
      map_o.addr = {scan_row_i, column_sel_i};
    end else begin
      map_o.addr = {row, col};
    end
  end

endmodule

// ===== sv/lpbm_ctrl.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lpbm_ctrl
// Sequencer of the store: clearing pass after reset, then one item at a time
// as a read of the addressed word followed by write-back or result.
// -----------------------------------------------------------------------------
module lpbm_ctrl import lpbm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                req_type_i,
  input  logic [1:0]          plane_sel_i,
  input  lpbm_map_t           map_i,
  input  logic [RamWidth-1:0] rdata_i,
  output logic [RamAddrW-1:0] raddr_o,
  output lpbm_wr_t            wr_o,
  output logic                busy_o,
  output logic                done_o,
  output logic [EntryW-1:0]   plane_byte_o
);

  state_e              state_q, state_d;
  logic [RamAddrW-1:0] clr_cnt_q, clr_cnt_d;
  logic                accept;

  // accepted item
  logic                req_read_q;
  logic [1:0]          plane_q;
  lpbm_map_t           map_q;

  logic [RamWidth-1:0] new_word;
  logic [EntryW-1:0]   old_entry;

  assign accept  = start_i && (state_q == ST_IDLE);
  // the read is issued at the accept edge; data is there in ST_EXEC
  assign raddr_o = map_i.addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_read_q <= (req_type_i == REQ_READ);
      plane_q    <= plane_sel_i;
      map_q      <= map_i;
    end
  end

  // Merge the new slot bits into every plane entry
  always_comb begin
    for (int p = 0; p < NumPlanes; p++) begin
      old_entry = rdata_i[p*EntryW +: EntryW];
      if (map_q.upper) begin
        new_word[p*EntryW +: EntryW] = {map_q.bits[p], old_entry[SlotW-1:0]};
      end else begin
        new_word[p*EntryW +: EntryW] = {old_entry[EntryW-1:SlotW], map_q.bits[p]};
      end
    end
  end

  // Next state and outputs
  always_comb begin
    state_d      = state_q;
    clr_cnt_d    = clr_cnt_q;
    wr_o.we      = 1'b0;
    wr_o.addr    = map_q.addr;
    wr_o.data    = new_word;
    busy_o       = 1'b1;
    done_o       = 1'b0;
    plane_byte_o = '0;
    unique case (state_q)
      ST_CLEAR: begin
        wr_o.we   = 1'b1;
        wr_o.addr = clr_cnt_q;
        wr_o.data = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == RamAddrW'(RamDepth - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        if (req_read_q) begin
          done_o = 1'b1;
          // plane three names no plane and reads as zero
          if (32'(plane_q) < NumPlanes) begin
            plane_byte_o = rdata_i[EntryW*plane_q +: EntryW];
          end
        end else begin
          wr_o.we = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/led_panel_bitplane_mapper.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// led_panel_bitplane_mapper
// Bitplane store of a 64x64 LED wall of 2x2 scan panels: pixel writes are
// read-modify-written into three planes, reads return one stored entry.
// -----------------------------------------------------------------------------
//  channel   | handshake                  | payload
//  ----------+----------------------------+----------------------------------
//  request   | start_i, busy_o            | req_type_i, x_pos_i, y_pos_i,
//            |                            | color_i, plane_sel_i, scan_row_i,
//            |                            | column_sel_i
//  result    | done_o (one-cycle strobe)  | plane_byte_o
//
//  Each item runs as the RAM read at the accept edge, then the write-back
//  or the result strobe; the next item is taken the cycle after. This order
//  is set by the registered read of the single store RAM. After reset a
//  clearing pass writes zero to all 2048 RAM words with busy_o high. A read
//  gives its result in the cycle after acceptance; a write gives none. The
//  receiver cannot stall.
// -----------------------------------------------------------------------------
module led_panel_bitplane_mapper import lpbm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        req_type_i,
  input  logic [5:0]  x_pos_i,
  input  logic [5:0]  y_pos_i,
  input  logic [15:0] color_i,
  input  logic [1:0]  plane_sel_i,
  input  logic [2:0]  scan_row_i,
  input  logic [7:0]  column_sel_i,
  output logic        done_o,
  output logic [5:0]  plane_byte_o
);

  lpbm_map_t           map;
  lpbm_wr_t            wr;
  logic [RamAddrW-1:0] raddr;
  logic [RamWidth-1:0] rdata;

  // Pixel mapping
  lpbm_map u_map (
    .req_type_i  (req_type_i),
    .x_pos_i     (x_pos_i),
    .y_pos_i     (y_pos_i),
    .color_i     (color_i),
    .scan_row_i  (scan_row_i),
    .column_sel_i(column_sel_i),
    .map_o       (map)
  );

  // Sequencer
  lpbm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_type_i  (req_type_i),
    .plane_sel_i (plane_sel_i),
    .map_i       (map),
    .rdata_i     (rdata),
    .raddr_o     (raddr),
    .wr_o        (wr),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .plane_byte_o(plane_byte_o)
  );

  // Plane store
  lpbm_ram #(
    .Width(RamWidth),
    .Depth(RamDepth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr.we),
    .waddr_i(wr.addr),
    .wdata_i(wr.data),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

endmodule

// ===== sv/lpbm_checker.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lpbm_checker
// Port-level checks of the bitplane mapper, bound to the top level.
// -----------------------------------------------------------------------------
module lpbm_checker import lpbm_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        req_type_i,
  input logic        done_o,
  input logic [5:0]  plane_byte_o
);

  // result only while an item is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o)
    else $error("result strobe outside an item");

  // an accepted read gives its result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && req_type_i == REQ_READ) |=> done_o)
    else $error("read item gave no result");

  // an accepted write gives no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && req_type_i == REQ_WRITE) |=> (busy_o && !done_o))
    else $error("write item misbehaved");

  // after a result the block is free again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!busy_o && !done_o))
    else $error("block not free after result");

  // result byte stays zero between strobes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> (plane_byte_o == '0))
    else $error("result byte driven without strobe");

endmodule

bind led_panel_bitplane_mapper lpbm_checker u_lpbm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .req_type_i  (req_type_i),
  .done_o      (done_o),
  .plane_byte_o(plane_byte_o)
);

// ===== tb/sv/led_panel_bitplane_mapper_tb.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// led_panel_bitplane_mapper_tb
// Self-checking bench for the bitplane mapper. A shadow copy of the three
// planes is updated on every accepted pixel write. Each accepted read queues
// the plane byte that it must return, and each done strobe is checked against
// the oldest queued byte. A directed pass covers corners, slots and levels;
// random bursts of writes and reads back follow.
// -----------------------------------------------------------------------------
module led_panel_bitplane_mapper_tb;
  import lpbm_pkg::*;

  localparam int NumRandom  = 1600;
  localparam int CycleLimit = 200000;
  localparam int TailCycles = 10;
  localparam int MaxReports = 10;

  // Shadow of the plane store plus the queue of bytes that reads must return
  class bitplane_shadow;
    bit [5:0] plane_q[3][8][256];
    bit [5:0] expected_bytes[$];
    int       mismatch_count;

    function new();
      mismatch_count = 0;
    endfunction

    // 2-bit level to 3-bit thermometer code
    function bit [2:0] level_code(input bit [1:0] level);
      return {level == 2'd3, level >= 2'd2, level != 2'd0};
    endfunction

    // Pixel position to scan row, shifted column and slot
    function void map_pixel(input bit [5:0] x, input bit [5:0] y,
                            output bit [2:0] row, output bit [7:0] col,
                            output bit upper);
      bit [1:0] pan;
      bit [1:0] seg;
      bit [7:0] base;
      pan   = 2'(x[5]) + y[5:4];
      base  = y[3] ? {3'b000, x[4:0]} : 8'd32 + {3'b000, x[4:0]};
      upper = y[4];
      seg   = upper ? pan + 2'd3 : pan;
      row   = y[2:0];
      col   = base + {seg, 6'b000000};
    endfunction

    // Read-modify-write of one slot in all three planes
    function void apply_pixel(input bit [5:0] x, input bit [5:0] y, input bit [15:0] color);
      bit [2:0] row;
      bit [7:0] col;
      bit       upper;
      bit [2:0] red;
      bit [2:0] grn;
      bit [2:0] blu;
      bit [2:0] rgb;
      map_pixel(x, y, row, col, upper);
      red = level_code(color[15:14]);
      grn = level_code(color[10:9]);
      blu = level_code(color[4:3]);
      for (int p = 0; p < 3; p++) begin
        rgb = {blu[p], grn[p], red[p]};
        if (upper) plane_q[p][row][col][5:3] = rgb;
        else       plane_q[p][row][col][2:0] = rgb;
      end
    endfunction

    // Accepted item: update the shadow or queue the byte a read must return
    function void note_request(input req_type_e req, input bit [5:0] x, input bit [5:0] y,
                               input bit [15:0] color, input bit [1:0] plane,
                               input bit [2:0] row, input bit [7:0] col);
      if (req == REQ_READ) begin
        // plane three names no plane and reads back zero
        if (plane == 2'd3) expected_bytes.push_back(6'd0);
        else               expected_bytes.push_back(plane_q[plane][row][col]);
      end else begin
        apply_pixel(x, y, color);
      end
    endfunction

    function void check_plane_byte(input bit [5:0] actual);
      bit [5:0] want;
      if (expected_bytes.size() == 0) begin
        if (mismatch_count < MaxReports)
          $display("unexpected result: plane_byte=%02h", actual);
        mismatch_count++;
      end else begin
        want = expected_bytes.pop_front();
        if (want != actual) begin
          if (mismatch_count < MaxReports)
            $display("plane_byte mismatch: expected %02h, actual %02h", want, actual);
          mismatch_count++;
        end
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic        req_type_i;
  logic [5:0]  x_pos_i;
  logic [5:0]  y_pos_i;
  logic [15:0] color_i;
  logic [1:0]  plane_sel_i;
  logic [2:0]  scan_row_i;
  logic [7:0]  column_sel_i;
  logic        done_o;
  logic [5:0]  plane_byte_o;

  bitplane_shadow shadow;
  int             cycle_count;

  // recently written pixels, targets for read-back
  bit [5:0] recent_x[8];
  bit [5:0] recent_y[8];
  int       recent_wr;

  led_panel_bitplane_mapper u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .req_type_i   (req_type_i),
    .x_pos_i      (x_pos_i),
    .y_pos_i      (y_pos_i),
    .color_i      (color_i),
    .plane_sel_i  (plane_sel_i),
    .scan_row_i   (scan_row_i),
    .column_sel_i (column_sel_i),
    .done_o       (done_o),
    .plane_byte_o (plane_byte_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Sample at the rising edge: check results, note accepted items, watchdog
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      cycle_count++;
      if (done_o === 1'b1) shadow.check_plane_byte(plane_byte_o);
      if (start_i === 1'b1 && busy_o === 1'b0)
        shadow.note_request(req_type_e'(req_type_i), x_pos_i, y_pos_i, color_i,
                            plane_sel_i, scan_row_i, column_sel_i);
      if (cycle_count > CycleLimit) begin
        $display("** led_panel_bitplane_mapper: FAILED **");
        $finish;
      end
    end
  end

  // Hold the item (called at a falling edge) until accepted, return at the next falling edge
  task automatic hold_until_taken();
    start_i = 1'b1;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    @(negedge clk_i);
  endtask

  task automatic send_write(input bit [5:0] x, input bit [5:0] y, input bit [15:0] color);
    req_type_i   = REQ_WRITE;
    x_pos_i      = x;
    y_pos_i      = y;
    color_i      = color;
    plane_sel_i  = 2'($urandom);
    scan_row_i   = 3'($urandom);
    column_sel_i = 8'($urandom);
    recent_x[recent_wr] = x;
    recent_y[recent_wr] = y;
    recent_wr = (recent_wr + 1) % 8;
    hold_until_taken();
  endtask

  task automatic send_read(input bit [1:0] plane, input bit [2:0] row, input bit [7:0] col);
    req_type_i   = REQ_READ;
    x_pos_i      = 6'($urandom);
    y_pos_i      = 6'($urandom);
    color_i      = 16'($urandom);
    plane_sel_i  = plane;
    scan_row_i   = row;
    column_sel_i = col;
    hold_until_taken();
  endtask

  // Read back the entry that a pixel maps to
  task automatic read_pixel(input bit [5:0] x, input bit [5:0] y, input bit [1:0] plane);
    bit [2:0] row;
    bit [7:0] col;
    bit       upper;
    shadow.map_pixel(x, y, row, col, upper);
    send_read(plane, row, col);
  endtask

  task automatic idle_cycles(input int n);
    start_i = 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  // One random item: writes, reads of recent pixels, and stray reads
  task automatic random_item();
    int       kind;
    int       slot;
    bit [5:0] x;
    bit [5:0] y;
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      if ($urandom_range(0, 1)) begin
        // small hot set so lower and upper slots of one entry collide
        x = {5'($urandom_range(0, 1)), 1'b0} << 4 | 6'($urandom_range(0, 1));
        y = 6'($urandom_range(0, 3) << 4) | 6'($urandom_range(0, 1) << 3)
            | 6'($urandom_range(0, 1));
      end else begin
        x = 6'($urandom);
        y = 6'($urandom);
      end
      send_write(x, y, 16'($urandom));
    end else if (kind < 80) begin
      slot = $urandom_range(0, 7);
      read_pixel(recent_x[slot], recent_y[slot], 2'($urandom_range(0, 2)));
    end else begin
      send_read(2'($urandom_range(0, 3)), 3'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    int burst_left;

    shadow       = new();
    cycle_count  = 0;
    recent_wr    = 0;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    req_type_i   = REQ_WRITE;
    x_pos_i      = '0;
    y_pos_i      = '0;
    color_i      = '0;
    plane_sel_i  = '0;
    scan_row_i   = '0;
    column_sel_i = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: cleared store, corners, shared entry, every level, plane three
    send_read(2'd0, 3'd0, 8'd0);
    send_read(2'd2, 3'd7, 8'd255);
    send_write(6'd0, 6'd0, 16'hFFFF);
    read_pixel(6'd0, 6'd0, 2'd0);
    read_pixel(6'd0, 6'd0, 2'd1);
    idle_cycles(1);
    read_pixel(6'd0, 6'd0, 2'd2);
    // lands in the upper slot of the same entry as pixel (0,0)
    send_write(6'd0, 6'd16, 16'h4208);
    read_pixel(6'd0, 6'd16, 2'd0);
    read_pixel(6'd0, 6'd16, 2'd1);
    send_write(6'd63, 6'd63, 16'hFFFF);
    idle_cycles(2);
    read_pixel(6'd63, 6'd63, 2'd2);
    send_write(6'd31, 6'd8, 16'h8410);
    read_pixel(6'd31, 6'd8, 2'd1);
    send_write(6'd32, 6'd16, 16'hC000);
    read_pixel(6'd32, 6'd16, 2'd0);
    // only unused colour bits set
    send_write(6'd63, 6'd0, 16'h39E7);
    read_pixel(6'd63, 6'd0, 2'd0);
    send_write(6'd0, 6'd0, 16'h0000);
    read_pixel(6'd0, 6'd0, 2'd0);
    send_read(2'd3, 3'd5, 8'd32);
    send_read(2'd3, 3'd7, 8'd255);

    // Random bursts; every third stretch of 200 items runs with no gaps
    burst_left = 0;
    for (int n = 0; n < NumRandom; n++) begin
      if (burst_left == 0) begin
        if ((n / 200) % 3 != 1) idle_cycles($urandom_range(1, 12));
        burst_left = $urandom_range(1, 24);
      end
      random_item();
      burst_left--;
    end
    start_i = 1'b0;

    while (shadow.pending() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (shadow.mismatch_count == 0 && shadow.pending() == 0) begin
      $display("** led_panel_bitplane_mapper: PASSED **");
    end else begin
      $display("** led_panel_bitplane_mapper: FAILED **");
    end
    $finish;
  end

endmodule
